@@ src/mnss_pkg.sv @@
// ----------------------------------------------------------------------------
// mnss_pkg
// Shared constants and codes for the multi needle stream stamper.
// ----------------------------------------------------------------------------
package mnss_pkg;

    localparam int NEEDLES      = 4;
    localparam int NEEDLE_BYTES = 8;
    localparam int HIST_DEPTH   = NEEDLE_BYTES - 1;
    localparam int HV_W         = $clog2(NEEDLE_BYTES);
    localparam int NB_IDX_W     = (NEEDLE_BYTES > 1) ? $clog2(NEEDLE_BYTES) : 1;
    localparam int LEN_W        = 4;
    localparam int MAX_LEN      = (NEEDLE_BYTES < 8) ? NEEDLE_BYTES : 8;
    localparam int PEND_W       = NEEDLES + 1;
    localparam int CNT_W        = 48;
    localparam int STAMP_W      = 64;
    localparam int CFG_IDX_W    = 3;

    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [STAMP_W-1:0] t_stamp;

    localparam t_count CNT_MAX   = '1;
    localparam t_count CAP_RESET = t_count'(65536);

    // input item kinds
    localparam logic [1:0] ITEM_DATA  = 2'd0;
    localparam logic [1:0] ITEM_END   = 2'd1;
    localparam logic [1:0] ITEM_ERROR = 2'd2;

    // result kinds
    localparam logic [1:0] RES_FWD    = 2'd0;
    localparam logic [1:0] RES_NEEDLE = 2'd1;
    localparam logic [1:0] RES_END    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_EN   = 3'd6;

endpackage

@@ src/multi_needle_stream_stamper_unit.sv @@
// ----------------------------------------------------------------------------
// multi_needle_stream_stamper_unit
// Forwards a timestamped byte stream under an optional cap, reports the first
// hit of each configured needle and gives an end report on end or error.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------------
//  input     | i_valid / o_stall        | i_item_kind, i_data_byte, i_timestamp
//  result    | o_valid / i_stall        | o_result_kind .. o_last
//  config    | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  an item is matched and counted in its accept cycle; its results sit in one
//  result bundle register and leave one per cycle while i_stall is low;
//  the next item is taken in the cycle the bundle's last result leaves
//  synchronous active-low reset clears counters, flags and pending results
//  config writes are taken every cycle
// ----------------------------------------------------------------------------
module multi_needle_stream_stamper_unit
    import mnss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_item_kind,
    input  logic [7:0]           i_data_byte,
    input  logic [STAMP_W-1:0]   i_timestamp,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_needle_index,
    output logic [STAMP_W-1:0]   o_stamp,
    output logic [CNT_W-1:0]     o_stream_offset,
    output logic [CNT_W-1:0]     o_stored_count,
    output logic [2:0]           o_fired_count,
    output logic                 o_end_status,
    output logic                 o_all_fired,
    output logic                 o_last,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // configuration registers
    logic [8*NEEDLE_BYTES-1:0] r_needle [NEEDLES];
    logic [15:0]               r_lengths;
    t_count                    r_cap;
    logic                      r_cap_en;

    // stream state
    logic [7:0]          r_hist [HIST_DEPTH];
    logic [HV_W-1:0]     r_hv;
    logic [NEEDLES-1:0]  r_fired;
    t_count              r_seen;
    t_count              r_fwd;

    // result bundle
    logic [PEND_W-1:0]   r_pend;
    logic                r_is_end;
    logic [7:0]          r_byte;
    t_stamp              r_stamp;
    t_count              r_offset;
    t_count              r_stored;
    logic [2:0]          r_fired_cnt;
    logic                r_status;
    logic                r_all;

    logic                in_fire;
    logic                out_fire;
    logic [PEND_W-1:0]   sel;
    logic [PEND_W-1:0]   rest;
    logic                is_data;
    logic                is_end;
    logic                fwd_ok;
    logic [NEEDLES-1:0]  hit;
    logic [NEEDLES-1:0]  active;
    logic [7:0]          win [NEEDLE_BYTES];
    t_count              seen_inc;
    logic [2:0]          fired_cnt;
    logic                all_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NEEDLES; k++) begin
                r_needle[k] <= '0;
            end
            r_lengths <= '0;
            r_cap     <= CAP_RESET;
            r_cap_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index inside {[CFG_NEEDLE_A:CFG_NEEDLE_D]}) begin
                r_needle[i_cfg_index[1:0]] <= i_cfg_data;
            end
            case (i_cfg_index)
                CFG_LENGTHS: r_lengths <= i_cfg_data[15:0];
                CFG_CAP:     r_cap     <= i_cfg_data[CNT_W-1:0];
                CFG_CAP_EN:  r_cap_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- matching ----------------

    function automatic logic [LEN_W-1:0] slot_len(input logic [15:0] lens, input int k);
        logic [LEN_W-1:0] l;
        l = lens[LEN_W*k +: LEN_W];
        if (l == '0 || l > LEN_W'(MAX_LEN)) begin
            l = '0;
        end
        return l;
    endfunction

    always_comb begin
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] idx;
        logic             ok;
        win[0] = i_data_byte;
        for (int j = 1; j < NEEDLE_BYTES; j++) begin
            win[j] = r_hist[j-1];
        end
        for (int k = 0; k < NEEDLES; k++) begin
            len       = slot_len(r_lengths, k);
            active[k] = (len != '0);
            ok        = active[k] && !r_fired[k] && ({1'b0, r_hv} >= (len - LEN_W'(1)));
            for (int j = 0; j < NEEDLE_BYTES; j++) begin
                // needle byte len-1-j lines up with the j-th most recent byte
                idx = len - LEN_W'(j) - LEN_W'(1);
                if (LEN_W'(j) < len &&
                    r_needle[k][{idx[NB_IDX_W-1:0], 3'b000} +: 8] != win[j]) begin
                    ok = 1'b0;
                end
            end
            hit[k] = ok;
        end
    end

    assign is_data  = (i_item_kind == ITEM_DATA);
    assign is_end   = (i_item_kind == ITEM_END) || (i_item_kind == ITEM_ERROR);
    assign fwd_ok   = !r_cap_en || (r_fwd < r_cap);
    assign seen_inc = (r_seen != CNT_MAX) ? r_seen + t_count'(1) : r_seen;

    always_comb begin
        fired_cnt = '0;
        all_ok    = 1'b1;
        for (int k = 0; k < NEEDLES; k++) begin
            fired_cnt = fired_cnt + 3'(r_fired[k]);
            if (active[k] && !r_fired[k]) begin
                all_ok = 1'b0;
            end
        end
    end

    // ---------------- handshake ----------------

    assign sel      = r_pend & (~r_pend + PEND_W'(1));
    assign rest     = r_pend & ~sel;
    assign o_valid  = |r_pend;
    assign out_fire = o_valid && !i_stall;
    assign o_stall  = o_valid && !(out_fire && (rest == '0));
    assign in_fire  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_hv    <= '0;
            r_fired <= '0;
            r_seen  <= '0;
            r_fwd   <= '0;
        end else begin
            if (in_fire) begin
                if (is_data) begin
                    r_pend <= {hit, fwd_ok};
                end else if (is_end) begin
                    r_pend <= PEND_W'(1);
                end else begin
                    r_pend <= '0;
                end
            end else if (out_fire) begin
                r_pend <= rest;
            end
            if (in_fire && is_data) begin
                r_seen  <= seen_inc;
                r_fired <= r_fired | hit;
                if (fwd_ok && r_fwd != CNT_MAX) begin
                    r_fwd <= r_fwd + t_count'(1);
                end
                if (r_hv != HV_W'(HIST_DEPTH)) begin
                    r_hv <= r_hv + HV_W'(1);
                end
            end else if (in_fire && is_end) begin
                r_seen  <= '0;
                r_fwd   <= '0;
                r_fired <= '0;
                r_hv    <= '0;
            end
        end
    end

    // history and bundle payload
    always_ff @(posedge i_clk) begin
        if (in_fire && is_data) begin
            r_hist[0] <= i_data_byte;
            for (int j = 1; j < HIST_DEPTH; j++) begin
                r_hist[j] <= r_hist[j-1];
            end
        end
        if (in_fire) begin
            r_is_end <= !is_data;
            r_byte   <= i_data_byte;
            r_stamp  <= i_timestamp;
            r_offset <= is_data ? seen_inc : r_seen;
            if (is_data) begin
                r_stored    <= '0;
                r_fired_cnt <= '0;
                r_status    <= 1'b0;
                r_all       <= 1'b0;
            end else begin
                r_stored    <= r_fwd;
                r_fired_cnt <= fired_cnt;
                r_status    <= (i_item_kind == ITEM_ERROR);
                r_all       <= (i_item_kind == ITEM_END) && all_ok;
            end
        end
    end

    // ---------------- result fields ----------------

    always_comb begin
        o_needle_index = '0;
        for (int k = 0; k < NEEDLES; k++) begin
            if (sel[k+1]) begin
                o_needle_index = 2'(k);
            end
        end
        if (r_is_end) begin
            o_result_kind  = RES_END;
            o_needle_index = '0;
        end else if (sel[0]) begin
            o_result_kind = RES_FWD;
        end else begin
            o_result_kind = RES_NEEDLE;
        end
    end

    assign o_out_byte      = (!r_is_end && sel[0]) ? r_byte : 8'd0;
    assign o_stamp         = r_stamp;
    assign o_stream_offset = r_offset;
    assign o_stored_count  = r_stored;
    assign o_fired_count   = r_fired_cnt;
    assign o_end_status    = r_status;
    assign o_all_fired     = r_all;
    assign o_last          = (rest == '0);

endmodule

@@ src/mnss_checker.sv @@
// ----------------------------------------------------------------------------
// mnss_checker
// Port-level checks for the multi needle stream stamper.
// ----------------------------------------------------------------------------
module mnss_checker
    import mnss_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [1:0]           o_result_kind,
    input logic [1:0]           o_needle_index,
    input logic [STAMP_W-1:0]   o_stamp,
    input logic [CNT_W-1:0]     o_stored_count,
    input logic [2:0]           o_fired_count,
    input logic                 o_end_status,
    input logic                 o_all_fired,
    input logic                 o_last
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) &&
        $stable(o_stamp) && $stable(o_needle_index) && $stable(o_last))
        else $error("result changed while stalled");

    // input is only held off while results are pending
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // an end report closes its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RES_END |-> o_last)
        else $error("end report not marked last");

    // report-only fields stay clear outside end reports
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != RES_END |->
        o_stored_count == '0 && o_fired_count == '0 && !o_end_status && !o_all_fired)
        else $error("end report fields set on a stream result");

endmodule

bind multi_needle_stream_stamper_unit mnss_checker u_mnss_checker (.*);
